[rtl/core/idc_pkg.sv]
// ----------------------------------------------------------------------------
// Identity number checker package
// Widths, codes, the weight and check-character tables and the small
// arithmetic helpers shared by the checker modules.
// ----------------------------------------------------------------------------
package idc_pkg;

  localparam int CharW   = 8;
  localparam int DigitW  = 4;
  localparam int YearW   = 14;
  localparam int FieldW  = 7;
  localparam int PosW    = 5;
  localparam int RemW    = 4;
  localparam int StatusW = 3;
  localparam int LimW    = 5;

  // Character positions, counted from zero
  localparam logic [PosW-1:0] IdLen      = PosW'(18);
  localparam logic [PosW-1:0] CheckPos   = PosW'(17);
  localparam logic [PosW-1:0] YearFirst  = PosW'(6);
  localparam logic [PosW-1:0] YearLoPos  = PosW'(8);
  localparam logic [PosW-1:0] YearLast   = PosW'(9);
  localparam logic [PosW-1:0] MonthFirst = PosW'(10);
  localparam logic [PosW-1:0] MonthLast  = PosW'(11);
  localparam logic [PosW-1:0] DayFirst   = PosW'(12);
  localparam logic [PosW-1:0] DayLast    = PosW'(13);

  localparam logic [CharW-1:0] CharZero = 8'd48;
  localparam logic [CharW-1:0] CharNine = 8'd57;
  localparam logic [CharW-1:0] CharX    = 8'd88;

  localparam logic [YearW-1:0] MinYearReset = 14'd1910;
  localparam logic [YearW-1:0] MaxYearReset = 14'd2010;

  localparam logic [FieldW-1:0] MonthMax = 7'd12;

  // Configuration register indexes
  localparam int CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] CFG_MIN_YEAR = 1'b0;
  localparam logic [CfgAddrW-1:0] CFG_MAX_YEAR = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_CHAR = 3'd1,
    ST_BAD_DATE = 3'd2,
    ST_CHECK    = 3'd3,
    ST_SHORT    = 3'd4
  } status_t;

  // Decimal fields gathered from the number. The year is also kept as its
  // two halves so that the leap-year rule needs no division.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] year_hi;
    logic [FieldW-1:0] year_lo;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
  } birth_t;

  function automatic logic [DigitW-1:0] weight(input logic [PosW-1:0] pos);
    logic [DigitW-1:0] w;
    case (pos)
      5'd0, 5'd10: w = 4'd7;
      5'd1, 5'd11: w = 4'd9;
      5'd2, 5'd12: w = 4'd10;
      5'd3, 5'd13: w = 4'd5;
      5'd4, 5'd14: w = 4'd8;
      5'd5, 5'd15: w = 4'd4;
      5'd6, 5'd16: w = 4'd2;
      5'd7:        w = 4'd1;
      5'd8:        w = 4'd6;
      5'd9:        w = 4'd3;
      default:     w = 4'd0;
    endcase
    return w;
  endfunction

  function automatic logic [CharW-1:0] check_char(input logic [RemW-1:0] rem);
    logic [CharW-1:0] c;
    case (rem)
      4'd0:    c = 8'd49;  // '1'
      4'd1:    c = 8'd48;  // '0'
      4'd2:    c = CharX;
      4'd3:    c = 8'd57;
      4'd4:    c = 8'd56;
      4'd5:    c = 8'd55;
      4'd6:    c = 8'd54;
      4'd7:    c = 8'd53;
      4'd8:    c = 8'd52;
      4'd9:    c = 8'd51;
      4'd10:   c = 8'd50;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [LimW-1:0] month_days(input logic [3:0] month);
    logic [LimW-1:0] d;
    case (month)
      4'd2:                   d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      default:                d = 5'd0;
    endcase
    return d;
  endfunction

  // Remainder modulo 11 of the running sum, which never exceeds 100. The
  // quotient comes from a multiplication by 47/512, which is exact for
  // every value below 109.
  function automatic logic [RemW-1:0] mod11(input logic [FieldW-1:0] x);
    logic [12:0]       prod;
    logic [FieldW-1:0] q;
    logic [FieldW-1:0] r;
    prod = 13'(x) * 13'd47;
    q    = FieldW'(prod[12:9]);
    r    = x - FieldW'(q * 7'd11);
    return r[RemW-1:0];
  endfunction

endpackage

[rtl/core/idc_date_check.sv]
// ----------------------------------------------------------------------------
// Identity number date check
// Decides whether the gathered birth date lies within the year bounds and
// names a real day of the Gregorian calendar.
// ----------------------------------------------------------------------------
module idc_date_check
  import idc_pkg::*;
(
  input  birth_t           birth,
  input  logic [YearW-1:0] min_year,
  input  logic [YearW-1:0] max_year,
  output logic             date_ok
);

  logic            year_ok;
  logic            month_ok;
  logic            leap;
  logic [LimW-1:0] lim;

  always_comb begin
    year_ok  = (birth.year >= min_year) && (birth.year <= max_year);
    month_ok = (birth.month != '0) && (birth.month <= MonthMax);
    // Century years are leap only when the century is divisible by four.
    if (birth.year_lo == '0) begin
      leap = (birth.year_hi[1:0] == 2'b00);
    end else begin
      leap = (birth.year_lo[1:0] == 2'b00);
    end
    lim = month_days(birth.month[3:0]);
    if ((birth.month == 7'd2) && leap) begin
      lim = 5'd29;
    end
    date_ok = year_ok && month_ok && (birth.day != '0) &&
              (birth.day <= FieldW'(lim));
  end

endmodule

[rtl/core/identity_number_checker.sv]
// ----------------------------------------------------------------------------
// Identity number checker
// Checks an 18-character identity number taken one character per
// transaction: character set, birth date and the MOD 11-2 check character.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  s_axis   | in        | tdata[7:0] character, tlast marks the final character
//  m_axis   | out       | tdata[0] valid_res, tdata[3:1] status, rest zero
//  cfg      | in        | index 0 min_year, index 1 max_year (14 bits)
//
//  One character is taken every cycle while s_tready is high; the
//  per-character work is a single registered step through the running
//  sum, digit fields and date check; the result enters the output stage.
//  A two-entry output stage (result register plus skid register) keeps
//  s_tready high while one result waits; it falls only when both are full.
//  Reset (rst, synchronous) clears the number state and the output stage and
//  loads the default year bounds.
// ----------------------------------------------------------------------------
module identity_number_checker
  import idc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [CharW-1:0]    s_tdata,   // [7:0] character
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [0] valid_res, [3:1] status
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [YearW-1:0]    cfg_wdata
);

  logic [YearW-1:0] min_year;
  logic [YearW-1:0] max_year;

  logic [PosW-1:0] position, position_next;
  logic [RemW-1:0] remainder, remainder_next;
  birth_t          birth, birth_next;
  logic            format_bad, format_bad_next;
  logic            check_bad, check_bad_next;

  logic              accept;
  logic              is_digit;
  logic [DigitW-1:0] digit;
  logic [FieldW-1:0] sum;
  logic              date_ok;
  status_t           res_status;
  logic              res_valid;

  logic    out_valid;
  status_t out_status;
  logic    skid_valid;
  status_t skid_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MinYearReset;
      max_year <= MaxYearReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MIN_YEAR: min_year <= cfg_wdata;
        CFG_MAX_YEAR: max_year <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  // The date fields are final well before the check character, so the
  // registered values serve for the final character's verdict.
  idc_date_check u_date (
    .birth    (birth),
    .min_year (min_year),
    .max_year (max_year),
    .date_ok  (date_ok)
  );

  always_comb begin
    is_digit = (s_tdata >= CharZero) && (s_tdata <= CharNine);
    digit    = is_digit ? DigitW'(s_tdata - CharZero) : '0;
    sum      = FieldW'(remainder) + FieldW'(digit) * FieldW'(weight(position));

    position_next   = position;
    remainder_next  = remainder;
    birth_next      = birth;
    format_bad_next = format_bad;
    check_bad_next  = check_bad;

    if (position < CheckPos) begin
      format_bad_next = format_bad || !is_digit;
      remainder_next  = mod11(sum);
      if ((position >= YearFirst) && (position <= YearLast)) begin
        birth_next.year = YearW'(birth.year * 14'd10 + YearW'(digit));
        if (position < YearLoPos) begin
          birth_next.year_hi = FieldW'(birth.year_hi * 7'd10 + FieldW'(digit));
        end else begin
          birth_next.year_lo = FieldW'(birth.year_lo * 7'd10 + FieldW'(digit));
        end
      end else if ((position >= MonthFirst) && (position <= MonthLast)) begin
        birth_next.month = FieldW'(birth.month * 7'd10 + FieldW'(digit));
      end else if ((position >= DayFirst) && (position <= DayLast)) begin
        birth_next.day = FieldW'(birth.day * 7'd10 + FieldW'(digit));
      end
    end else if (position == CheckPos) begin
      format_bad_next = format_bad || !(is_digit || (s_tdata == CharX));
      check_bad_next  = check_bad || (s_tdata != check_char(remainder));
    end
    if (position < IdLen) begin
      position_next = position + PosW'(1);
    end

    if (position_next < IdLen) begin
      res_status = ST_SHORT;
    end else if (format_bad_next) begin
      res_status = ST_BAD_CHAR;
    end else if (!date_ok) begin
      res_status = ST_BAD_DATE;
    end else if (check_bad_next) begin
      res_status = ST_CHECK;
    end else begin
      res_status = ST_OK;
    end
    res_valid = accept && s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      remainder  <= '0;
      birth      <= '0;
      format_bad <= 1'b0;
      check_bad  <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        position   <= '0;
        remainder  <= '0;
        birth      <= '0;
        format_bad <= 1'b0;
        check_bad  <= 1'b0;
      end else begin
        position   <= position_next;
        remainder  <= remainder_next;
        birth      <= birth_next;
        format_bad <= format_bad_next;
        check_bad  <= check_bad_next;
      end
    end
  end

  // Output stage: a result that cannot enter the output register waits in
  // the skid register, which then holds off further transactions.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      out_status <= skid_valid ? skid_status : res_status;
    end else if (res_valid) begin
      skid_status <= res_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_status, (out_status == ST_OK)};

endmodule

[verif/identity_number_checker_tb.sv]
// ----------------------------------------------------------------------------
// Identity number checker testbench
// Streams identity numbers, both well-formed and broken, into the checker
// under several year-bound settings. A behavioural predictor works out the
// status of every number, and each result transaction is compared with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module identity_number_checker_tb
  import idc_pkg::*;
();

  localparam int CycleLimit = 400000;
  localparam int MaxGap     = 17;

  // Weights of characters 1 to 17 and days per month, element 0 first.
  localparam logic [16:0][3:0] WEIGHTS = {4'd2, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9,
                                          4'd7, 4'd3, 4'd6, 4'd1, 4'd2, 4'd4,
                                          4'd8, 4'd5, 4'd10, 4'd9, 4'd7};
  localparam logic [11:0][4:0] MONTH_LEN = {5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
                                            5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
                                            5'd28, 5'd31};
  // Check character for remainder r sits at character r from the left.
  localparam logic [87:0] CHECK_SEQ = "10X98765432";

  typedef struct packed {
    logic    valid_res;
    status_t status;
  } id_result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic [CharW-1:0]    s_tdata   = '0;
  logic                s_tlast   = 1'b0;
  logic                m_tready  = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = CFG_MIN_YEAR;
  logic [YearW-1:0]    cfg_wdata = '0;
  wire                 s_tready;
  wire                 m_tvalid;
  wire  [7:0]          m_tdata;

  // Predictor state: the number being gathered and the year bounds.
  int unsigned id_pos, id_rem, id_year, id_month, id_day;
  bit          id_char_bad, id_check_bad;
  int unsigned year_lo = MinYearReset;
  int unsigned year_hi = MaxYearReset;

  id_result_t  expected_results[$];
  id_result_t  head;
  logic [7:0]  id_chars[$];

  int errors, cycles, chars_sent, reg_writes;
  int status_seen[5];
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int rx_wait, hold_left;

  identity_number_checker DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("Mismatch in %s at cycle %0d: got %h, expected %h", what, cycles, got, want);
    errors++;
  endtask

  function automatic logic [7:0] check_for(input int unsigned r);
    return CHECK_SEQ[(10 - r) * 8 +: 8];
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    bit leap;
    leap = (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    return (m == 2 && leap) ? 29 : MONTH_LEN[m - 1];
  endfunction

  function automatic bit date_good();
    if (id_year < year_lo || id_year > year_hi) return 1'b0;
    if (id_month < 1 || id_month > 12) return 1'b0;
    return id_day >= 1 && id_day <= month_length(id_year, id_month);
  endfunction

  // Folds one accepted character into the number and, on the final one,
  // queues the status that the checker should report.
  function automatic void absorb_char(input logic [7:0] c, input logic is_last);
    bit          is_digit;
    int unsigned d;
    status_t     st;
    id_result_t  r;
    is_digit = c >= CharZero && c <= CharNine;
    d = is_digit ? c - CharZero : 0;
    if (id_pos < 17) begin
      if (!is_digit) id_char_bad = 1'b1;
      id_rem = (id_rem + d * WEIGHTS[id_pos]) % 11;
      if (id_pos >= 6 && id_pos <= 9) id_year = (id_year * 10 + d) & 14'h3FFF;
      else if (id_pos >= 10 && id_pos <= 11) id_month = (id_month * 10 + d) & 7'h7F;
      else if (id_pos >= 12 && id_pos <= 13) id_day = (id_day * 10 + d) & 7'h7F;
      id_pos++;
    end else if (id_pos == 17) begin
      if (!is_digit && c != CharX) id_char_bad = 1'b1;
      if (c != check_for(id_rem)) id_check_bad = 1'b1;
      id_pos++;
    end
    if (!is_last) return;
    if (id_pos < 18) st = ST_SHORT;
    else if (id_char_bad) st = ST_BAD_CHAR;
    else if (!date_good()) st = ST_BAD_DATE;
    else if (id_check_bad) st = ST_CHECK;
    else st = ST_OK;
    r.valid_res = (st == ST_OK);
    r.status = st;
    expected_results = {expected_results, r};
    id_pos = 0;
    id_rem = 0;
    id_year = 0;
    id_month = 0;
    id_day = 0;
    id_char_bad = 1'b0;
    id_check_bad = 1'b0;
  endfunction

  function automatic void add_char(input logic [7:0] c);
    id_chars = {id_chars, c};
  endfunction

  // Result checker; also draws the receiver's wait before the next result.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", m_tdata, 8'h00);
      end else begin
        head = expected_results.pop_front();
        if (m_tdata[0] !== head.valid_res)
          report_mismatch("valid_res", m_tdata[0], head.valid_res);
        if (m_tdata[3:1] !== head.status)
          report_mismatch("status", m_tdata[3:1], head.status);
        if (m_tdata[7:4] !== 4'd0)
          report_mismatch("padding", m_tdata[7:4], 8'h00);
        status_seen[head.status]++;
      end
      rx_wait = rx_gaps ? $urandom_range(0, MaxGap) : 0;
    end
  end

  // Receiver: a long hold-off takes precedence over the per-result wait.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (rx_wait > 0) begin
      m_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    gap = tx_gaps ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
    absorb_char(c, is_last);
    @(negedge clk);
  endtask

  task automatic send_id(input bit stray_last);
    for (int i = 0; i < id_chars.size(); i++)
      send_char(id_chars[i], i == id_chars.size() - 1 ||
                             (stray_last && $urandom_range(0, 15) == 0));
  endtask

  // The block may still be folding in a character that yields no result,
  // so the clock runs on past the last result before anything else.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input int unsigned val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= YearW'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_YEAR) year_lo = val;
    else year_hi = val;
    reg_writes++;
  endtask

  task automatic set_bounds(input int unsigned lo, input int unsigned hi);
    write_reg(CFG_MIN_YEAR, lo);
    write_reg(CFG_MAX_YEAR, hi);
  endtask

  // Builds a number with random region and sequence digits and the
  // matching check character.
  function automatic void compose_id(input int unsigned y, input int unsigned m,
                                     input int unsigned d);
    int unsigned sum;
    id_chars.delete();
    repeat (6) add_char(CharZero + 8'($urandom_range(0, 9)));
    for (int k = 1000; k >= 1; k /= 10) add_char(CharZero + 8'((y / k) % 10));
    add_char(CharZero + 8'((m / 10) % 10));
    add_char(CharZero + 8'(m % 10));
    add_char(CharZero + 8'((d / 10) % 10));
    add_char(CharZero + 8'(d % 10));
    repeat (3) add_char(CharZero + 8'($urandom_range(0, 9)));
    sum = 0;
    for (int i = 0; i < 17; i++) sum = (sum + (id_chars[i] - CharZero) * WEIGHTS[i]) % 11;
    add_char(check_for(sum));
  endfunction

  task automatic send_dated(input int unsigned y, input int unsigned m, input int unsigned d);
    compose_id(y, m, d);
    send_id(1'b0);
  endtask

  task automatic test_well_formed();
    send_dated(1985, 7, 23);
    send_dated(1910, 1, 1);
    send_dated(2010, 12, 31);
    do compose_id(1990, 6, 15); while (id_chars[17] != CharX);
    send_id(1'b0);
  endtask

  task automatic test_characters();
    compose_id(1985, 3, 3);
    id_chars[2] = 8'h00;
    send_id(1'b0);
    compose_id(1985, 3, 4);
    id_chars[17] = 8'hFF;
    send_id(1'b0);
    do compose_id(1990, 6, 15); while (id_chars[17] != CharX);
    id_chars[17] = "x";
    send_id(1'b0);
    compose_id(1977, 11, 9);
    id_chars[16] = ":";
    send_id(1'b0);
    compose_id(1977, 11, 9);
    id_chars[0] = "/";
    send_id(1'b0);
  endtask

  task automatic test_dates();
    send_dated(1985, 0, 10);
    send_dated(1985, 5, 0);
    send_dated(1985, 13, 1);
    send_dated(1985, 4, 31);
    send_dated(1985, 1, 32);
    send_dated(2001, 2, 29);
    send_dated(2000, 2, 29);
    send_dated(2004, 2, 29);
    send_dated(1909, 12, 31);
    send_dated(2011, 1, 1);
    send_dated(1985, 99, 99);
  endtask

  task automatic test_check_char();
    compose_id(1966, 8, 8);
    id_chars[17] = (id_chars[17] == CharZero) ? "1" : CharZero;
    send_id(1'b0);
  endtask

  task automatic test_length();
    id_chars = {"1"};
    send_id(1'b0);
    compose_id(1985, 2, 2);
    void'(id_chars.pop_back());
    send_id(1'b0);
    compose_id(1985, 2, 3);
    repeat (3) add_char(8'($urandom_range(0, 255)));
    send_id(1'b0);
    // A full number with no final flag stays open and gives nothing.
    compose_id(1999, 9, 9);
    foreach (id_chars[i]) send_char(id_chars[i], 1'b0);
    wait_drained();
    repeat (16) @(negedge clk);
    send_char("7", 1'b1);
  endtask

  task automatic test_priority();
    compose_id(1985, 5, 5);
    id_chars = id_chars[0:9];
    id_chars[3] = "A";
    send_id(1'b0);
    compose_id(1985, 13, 40);
    id_chars[0] = "Z";
    send_id(1'b0);
    compose_id(1985, 2, 30);
    id_chars[17] = (id_chars[17] == CharX) ? CharZero : CharX;
    send_id(1'b0);
    compose_id(1985, 0, 0);
    id_chars[17] = "x";
    send_id(1'b0);
  endtask

  task automatic test_year_bounds();
    set_bounds(0, 9999);
    send_dated(0, 1, 1);
    send_dated(9999, 12, 31);
    send_dated(1900, 2, 29);
    send_dated(1600, 2, 29);
    send_dated(0, 2, 29);
    // Crossed bounds reject every date.
    set_bounds(2000, 1999);
    send_dated(2000, 1, 1);
    send_dated(1999, 6, 6);
    set_bounds(2000, 2000);
    send_dated(2000, 2, 29);
    send_dated(2001, 1, 1);
    send_dated(1999, 12, 31);
  endtask

  // The receiver holds off while the sender keeps offering short numbers,
  // so the output stage fills and the input stalls.
  task automatic test_backpressure();
    wait_drained();
    @(posedge clk);
    hold_left = 200;
    @(negedge clk);
    tx_gaps = 1'b0;
    repeat (30) send_char(8'($urandom_range(0, 255)), 1'b1);
    repeat (3) send_dated(1950, 5, 17);
    tx_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic send_random_id();
    int unsigned y, m, d, kind, n;
    kind = $urandom_range(0, 99);
    if (year_lo <= year_hi && $urandom_range(0, 4) != 0) y = $urandom_range(year_lo, year_hi);
    else y = $urandom_range(0, 9999);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, month_length(y, m));
    case ($urandom_range(0, 19))
      0: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
      1: d = $urandom_range(0, 1) ? 0 : $urandom_range(month_length(y, m) + 1, 99);
      2: begin
        m = 2;
        d = 29;
      end
      default: ;
    endcase
    compose_id(y, m, d);
    if (kind < 62) begin
      send_id(1'b0);
    end else if (kind < 72) begin
      if ($urandom_range(0, 3) == 0) id_chars[17] = 8'($urandom_range(0, 255));
      else if ($urandom_range(0, 10) == 0) id_chars[17] = CharX;
      else id_chars[17] = CharZero + 8'($urandom_range(0, 9));
      send_id(1'b0);
    end else if (kind < 79) begin
      id_chars[$urandom_range(0, 16)] = 8'($urandom_range(0, 255));
      send_id(1'b0);
    end else if (kind < 85) begin
      n = $urandom_range(1, 17);
      repeat (n) void'(id_chars.pop_back());
      send_id(1'b0);
    end else if (kind < 91) begin
      n = $urandom_range(1, 6);
      repeat (n) add_char(8'($urandom_range(0, 255)));
      send_id(1'b0);
    end else begin
      id_chars.delete();
      n = $urandom_range(1, 24);
      repeat (n) add_char(8'($urandom_range(0, 255)));
      send_id(1'b1);
    end
  endtask

  task automatic test_random(input int unsigned lo, input int unsigned hi, input int target);
    int start;
    set_bounds(lo, hi);
    start = chars_sent;
    while (chars_sent - start < target) begin
      if ($urandom_range(0, 9) == 0) tx_gaps = !tx_gaps;
      if ($urandom_range(0, 9) == 0) rx_gaps = !rx_gaps;
      if ($urandom_range(0, 24) == 0) wait_drained();
      send_random_id();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    int unsigned a, b;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_well_formed();
    test_characters();
    test_dates();
    test_check_char();
    test_length();
    test_priority();
    test_year_bounds();
    test_backpressure();
    test_random(MinYearReset, MaxYearReset, 300);
    test_random(0, 9999, 300);
    a = $urandom_range(0, 9999);
    b = $urandom_range(0, 9999);
    test_random(a < b ? a : b, a < b ? b : a, 200);
    test_random(4000, 7000, 150);
    test_random(a < b ? b : a, a < b ? a : b, 80);
    a = $urandom_range(0, 9999);
    test_random(a, a, 80);
    wait_drained();
    repeat (20) @(negedge clk);
    $display("Sent %0d characters over %0d register writes; results: ok %0d, bad character %0d,",
             chars_sent, reg_writes, status_seen[ST_OK], status_seen[ST_BAD_CHAR]);
    $display("bad date %0d, check mismatch %0d, too short %0d; %0d mismatches.",
             status_seen[ST_BAD_DATE], status_seen[ST_CHECK], status_seen[ST_SHORT], errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
